FILE: rtl/cdt_pkg.sv
package cdt_pkg;

    localparam int BANK_SLOTS     = 8;
    localparam int NUM_TIMERS     = 8;
    localparam int TIME_BASE_LOG2 = 0;
    localparam int CHAN_W         = 3;
    localparam int COUNT_W        = 16;
    localparam int TIMEOUT_W      = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_REQUEST = 2'd1,
        OP_START   = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                  opcode;
        logic [CHAN_W-1:0]    channel;
        logic [TIMEOUT_W-1:0] timeout;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] granted_channel;
        logic              alloc_failed;
        logic              expired;
    } out_item_t;

    typedef struct packed {
        logic tick;
        logic alloc;
        logic start;
        logic query;
    } cmd_t;

    typedef enum logic {
        ST_EMPTY = 1'b0,
        ST_FULL  = 1'b1
    } ctl_state_t;

endpackage

FILE: rtl/cdt_ctrl.sv
module cdt_ctrl (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  cdt_pkg::op_t opcode,
    input  logic        out_ready,
    output logic        in_ready,
    output logic        out_valid,
    output cdt_pkg::cmd_t cmd
);

    cdt_pkg::ctl_state_t state_reg;
    cdt_pkg::ctl_state_t state_next;
    logic accept;
    logic has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdt_pkg::ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        in_ready   = (state_reg == cdt_pkg::ST_EMPTY) || out_ready;
        out_valid  = (state_reg == cdt_pkg::ST_FULL);
        accept     = in_valid && in_ready;
        has_result = (opcode == cdt_pkg::OP_REQUEST) || (opcode == cdt_pkg::OP_QUERY);

        cmd.tick  = accept && (opcode == cdt_pkg::OP_TICK);
        cmd.alloc = accept && (opcode == cdt_pkg::OP_REQUEST);
        cmd.start = accept && (opcode == cdt_pkg::OP_START);
        cmd.query = accept && (opcode == cdt_pkg::OP_QUERY);

        state_next = state_reg;
        unique case (state_reg)
            cdt_pkg::ST_EMPTY:
            begin
                if (accept && has_result)
                begin
                    state_next = cdt_pkg::ST_FULL;
                end
            end
            cdt_pkg::ST_FULL:
            begin
                if (out_ready)
                begin
                    state_next = (accept && has_result) ? cdt_pkg::ST_FULL
                                                        : cdt_pkg::ST_EMPTY;
                end
            end
            default:
            begin
                state_next = cdt_pkg::ST_EMPTY;
            end
        endcase
    end

endmodule

FILE: rtl/cdt_dp.sv
module cdt_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cdt_pkg::cmd_t                       cmd,
    input  logic [cdt_pkg::CHAN_W-1:0]          channel,
    input  logic [cdt_pkg::TIMEOUT_W-1:0]       timeout,
    output cdt_pkg::out_item_t                  out_item
);

    logic [cdt_pkg::COUNT_W-1:0]    count_reg [cdt_pkg::BANK_SLOTS];
    logic [cdt_pkg::COUNT_W-1:0]    count_next [cdt_pkg::BANK_SLOTS];
    logic [cdt_pkg::BANK_SLOTS-1:0] enabled_reg;
    logic [cdt_pkg::BANK_SLOTS-1:0] enabled_next;
    logic [cdt_pkg::BANK_SLOTS-1:0] allocated_reg;
    logic [cdt_pkg::BANK_SLOTS-1:0] allocated_next;
    cdt_pkg::out_item_t             out_item_reg;
    cdt_pkg::out_item_t             out_item_next;

    logic                           free_found;
    logic [cdt_pkg::CHAN_W-1:0]     free_idx;
    logic                           chan_ok;
    logic [cdt_pkg::TIMEOUT_W-1:0]  quotient;
    logic [cdt_pkg::COUNT_W-1:0]    load_val;

    always_comb
    begin
        // lowest free timer
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = cdt_pkg::BANK_SLOTS - 1; i >= 0; i--)
        begin
            if ((i < cdt_pkg::NUM_TIMERS) && !allocated_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = cdt_pkg::CHAN_W'(i);
            end
        end

        chan_ok  = {1'b0, channel} < (cdt_pkg::CHAN_W + 1)'(cdt_pkg::NUM_TIMERS);
        quotient = timeout >> cdt_pkg::TIME_BASE_LOG2;
        load_val = (quotient > cdt_pkg::TIMEOUT_W'(cdt_pkg::COUNT_MAX))
                   ? cdt_pkg::COUNT_MAX : quotient[cdt_pkg::COUNT_W-1:0];

        enabled_next   = enabled_reg;
        allocated_next = allocated_reg;
        for (int i = 0; i < cdt_pkg::BANK_SLOTS; i++)
        begin
            count_next[i] = count_reg[i];
            if (cmd.start && chan_ok && (channel == cdt_pkg::CHAN_W'(i)))
            begin
                count_next[i]   = load_val;
                enabled_next[i] = 1'b1;
            end
            else if (cmd.tick && enabled_reg[i] && (count_reg[i] != '0))
            begin
                count_next[i] = count_reg[i] - 1'b1;
            end
            if (cmd.alloc && free_found && (free_idx == cdt_pkg::CHAN_W'(i)))
            begin
                allocated_next[i] = 1'b1;
            end
        end

        out_item_next = out_item_reg;
        if (cmd.alloc)
        begin
            out_item_next.granted_channel = free_found ? free_idx : '0;
            out_item_next.alloc_failed    = !free_found;
            out_item_next.expired         = 1'b0;
        end
        else if (cmd.query)
        begin
            out_item_next.granted_channel = '0;
            out_item_next.alloc_failed    = 1'b0;
            out_item_next.expired         = chan_ok && enabled_reg[channel]
                                            && (count_reg[channel] == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= '0;
            allocated_reg <= '0;
        end
        else
        begin
            enabled_reg   <= enabled_next;
            allocated_reg <= allocated_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg    <= count_next;
        out_item_reg <= out_item_next;
    end

    assign out_item = out_item_reg;

endmodule

FILE: rtl/countdown_timer_bank_unit.sv
// bank of eight 16-bit countdown timers with allocate, start, tick and status
// input channel: in_valid/in_ready with in_item (opcode, channel, timeout)
// output channel: out_valid/out_ready with out_item
// tick and start update state and give no result item
// request and query give one result item, registered in the cycle after accept
// one item per cycle as long as out_ready stays high; the single output
// register sets this: a held result blocks new input until it is taken
// start loads timeout shifted down by the time base, saturated to 16 bits
// reset clears the allocated and enabled masks and empties the output register
// counters are not reset; they are read only after a start has loaded them
// when the receiver stalls, the result stays in the output register and
// in_ready drops until out_ready returns
module countdown_timer_bank_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cdt_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output cdt_pkg::out_item_t  out_item
);

    cdt_pkg::cmd_t cmd;

    cdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (in_item.opcode),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    cdt_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .channel  (in_item.channel),
        .timeout  (in_item.timeout),
        .out_item (out_item)
    );

endmodule

FILE: rtl/cdt_checker.sv
module cdt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input cdt_pkg::in_item_t   in_item,
    input logic                out_valid,
    input logic                out_ready,
    input cdt_pkg::out_item_t  out_item
);

    logic in_acc;
    logic out_held;

    assign in_acc   = in_valid && in_ready;
    assign out_held = out_valid && !out_ready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_held |=> out_valid && $stable(out_item))
        else $error("result item dropped or changed while stalled");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_held |-> !in_ready)
        else $error("input taken while result is stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && ((in_item.opcode == cdt_pkg::OP_REQUEST)
                   || (in_item.opcode == cdt_pkg::OP_QUERY)) |=> out_valid)
        else $error("missing result item");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !out_held && ((in_item.opcode == cdt_pkg::OP_TICK)
                                || (in_item.opcode == cdt_pkg::OP_START)) |=> !out_valid)
        else $error("result item without request or query");

    a_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.alloc_failed && out_item.expired))
        else $error("failure and expired both set");

endmodule

bind countdown_timer_bank_unit cdt_checker u_cdt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
